### hw/rtl/bgc_pkg.sv
`timescale 1ns / 1ps

package bgc_pkg;

   localparam int TIME_BITS = 32;
   localparam int NOW_BITS  = 32;
   localparam int THR_BITS  = 16;
   localparam int CSR_IDX_BITS = 2;

   typedef logic [TIME_BITS-1:0]    time_type;
   typedef logic [NOW_BITS-1:0]     now_type;
   typedef logic [THR_BITS-1:0]     thr_type;
   typedef logic [CSR_IDX_BITS-1:0] csr_index_type;

   typedef enum logic [1:0] {
      GEST_NONE   = 2'd0,
      GEST_SINGLE = 2'd1,
      GEST_DOUBLE = 2'd2,
      GEST_LONG   = 2'd3
   } gesture_type;

   localparam csr_index_type CSR_DEBOUNCE_TIME = 2'd0;
   localparam csr_index_type CSR_DOUBLE_WINDOW = 2'd1;
   localparam csr_index_type CSR_LONG_TIME     = 2'd2;

   localparam thr_type DEBOUNCE_TIME_RESET = 16'd30;
   localparam thr_type DOUBLE_WINDOW_RESET = 16'd450;
   localparam thr_type LONG_TIME_RESET     = 16'd1500;

   typedef struct packed {
      thr_type debounce_time;
      thr_type double_window;
      thr_type long_time;
   } cfg_type;

endpackage

### hw/rtl/bgc_req_if.sv
`timescale 1ns / 1ps

interface bgc_req_if import bgc_pkg::*; ();
   logic    valid;
   logic    ready;
   logic    level_pressed;
   now_type now_ms;

   modport source (output valid, output level_pressed, output now_ms, input ready);
   modport sink   (input valid, input level_pressed, input now_ms, output ready);
endinterface

### hw/rtl/bgc_rsp_if.sv
`timescale 1ns / 1ps

interface bgc_rsp_if ();
   logic       valid;
   logic       ready;
   logic [1:0] gesture;
   logic       debounced_level;

   modport source (output valid, output gesture, output debounced_level, input ready);
   modport sink   (input valid, input gesture, input debounced_level, output ready);
endinterface

### hw/rtl/bgc_csr_if.sv
`timescale 1ns / 1ps

interface bgc_csr_if import bgc_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   thr_type       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/button_gesture_classifier.sv
`timescale 1ns / 1ps

// Button gesture classifier.
// The req channel carries one poll sample per item: the raw level (1 = pressed)
// and a free-running millisecond timestamp. For every sample the rsp channel
// returns exactly one item: a gesture code (none, single, double, long) and the
// debounced level after that sample, in the order the samples were taken.
// The csr channel writes the debounce time, double-tap window and long-press
// time; it is always ready and should only be used while no sample is in flight.
// A sample accepted is registered in the input register, and its result is
// loaded into the output register once that register is empty or being read.
// Throughput is one item per cycle while the receiver is ready, set by the state
// update (three subtract-and-compare paths feeding the gesture flags).
// Reset restores the default thresholds (30, 450, 1500 ms) and clears all
// gesture state. When the receiver stalls, the result holds in the output
// register and one further sample waits in the input register; ready drops
// only when both are full.

module button_gesture_classifier import bgc_pkg::*; (
   input  logic clock,
   input  logic reset,
   bgc_req_if.sink   req_chan,
   bgc_rsp_if.source rsp_chan,
   bgc_csr_if.sink   csr_chan
);

   logic        in_valid_ff, in_valid_in;
   logic        in_level_ff;
   time_type    in_now_ff;
   logic        out_valid_ff, out_valid_in;
   gesture_type out_gesture_ff;
   logic        out_level_ff;

   logic        advance, move, take;
   cfg_type     cfg;
   gesture_type core_gesture;
   logic        core_held;

   assign advance = !out_valid_ff || rsp_chan.ready;
   assign move    = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign take    = req_chan.valid && req_chan.ready;

   assign csr_chan.ready = 1'b1;

   bgc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   bgc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (move),
      .level   (in_level_ff),
      .now     (in_now_ff),
      .cfg     (cfg),
      .gesture (core_gesture),
      .held    (core_held)
   );

   always_comb begin
      in_valid_in  = take || (in_valid_ff && !advance);
      out_valid_in = move || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_level_ff <= req_chan.level_pressed;
         in_now_ff   <= time_type'(req_chan.now_ms);
      end
      if (move) begin
         out_gesture_ff <= core_gesture;
         out_level_ff   <= core_held;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.gesture         = out_gesture_ff;
   assign rsp_chan.debounced_level = out_level_ff;

`ifndef SYNTHESIS
   a_long_while_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_gesture_ff == GEST_LONG) |-> out_level_ff)
      else $error("long press reported with the button released");

   a_tap_while_released: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && ((out_gesture_ff == GEST_SINGLE) || (out_gesture_ff == GEST_DOUBLE))
      |-> !out_level_ff)
      else $error("tap reported with the button held");

   a_ready_low_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> in_valid_ff && out_valid_ff)
      else $error("input stalled with a free stage");

   a_stalled_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("waiting item lost from the input register");
`endif

endmodule

### hw/rtl/bgc_csr.sv
`timescale 1ns / 1ps

module bgc_csr import bgc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  csr_index_type wr_index,
   input  thr_type       wr_data,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_DEBOUNCE_TIME: cfg_in.debounce_time = wr_data;
            CSR_DOUBLE_WINDOW: cfg_in.double_window = wr_data;
            CSR_LONG_TIME:     cfg_in.long_time     = wr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time <= DEBOUNCE_TIME_RESET;
         cfg_ff.double_window <= DOUBLE_WINDOW_RESET;
         cfg_ff.long_time     <= LONG_TIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/bgc_core.sv
`timescale 1ns / 1ps

module bgc_core import bgc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        level,
   input  time_type    now,
   input  cfg_type     cfg,
   output gesture_type gesture,
   output logic        held
);

   logic     held_ff, held_in;
   time_type last_change_ff, last_change_in;
   time_type press_start_ff, press_start_in;
   logic     tap_pending_ff, tap_pending_in;
   time_type first_release_ff, first_release_in;
   logic     long_done_ff, long_done_in;

   time_type el_last, el_press, el_first;
   logic     change, press, release_tap, new_tap, fire_long, fire_single;
   logic     tap_mid;

   // All three differences are taken against the stored times; where a time is
   // replaced by now in this sample, the check on it is masked by !press or !new_tap.
   assign el_last  = now - last_change_ff;
   assign el_press = now - press_start_ff;
   assign el_first = now - first_release_ff;

   always_comb begin
      gesture          = GEST_NONE;
      held_in          = held_ff;
      last_change_in   = last_change_ff;
      press_start_in   = press_start_ff;
      first_release_in = first_release_ff;
      long_done_in     = long_done_ff;
      tap_mid          = tap_pending_ff;

      change      = (level != held_ff) && (el_last > time_type'(cfg.debounce_time));
      press       = change && level;
      release_tap = change && !level && !long_done_ff;
      new_tap     = release_tap && !tap_pending_ff;

      if (change) begin
         held_in        = level;
         last_change_in = now;
      end
      if (press) begin
         press_start_in = now;
         long_done_in   = 1'b0;
      end
      if (release_tap) begin
         if (!tap_pending_ff) begin
            tap_mid          = 1'b1;
            first_release_in = now;
         end else begin
            tap_mid = 1'b0;
            gesture = GEST_DOUBLE;
         end
      end

      fire_long = held_in && !long_done_in && !press
                  && (el_press > time_type'(cfg.long_time));
      tap_pending_in = tap_mid;
      if (fire_long) begin
         long_done_in   = 1'b1;
         tap_pending_in = 1'b0;
         gesture        = GEST_LONG;
      end

      fire_single = tap_pending_in && !held_in && !new_tap
                    && (el_first > time_type'(cfg.double_window));
      if (fire_single) begin
         tap_pending_in = 1'b0;
         gesture        = GEST_SINGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff          <= 1'b0;
         last_change_ff   <= '0;
         press_start_ff   <= '0;
         tap_pending_ff   <= 1'b0;
         first_release_ff <= '0;
         long_done_ff     <= 1'b0;
      end else if (step) begin
         held_ff          <= held_in;
         last_change_ff   <= last_change_in;
         press_start_ff   <= press_start_in;
         tap_pending_ff   <= tap_pending_in;
         first_release_ff <= first_release_in;
         long_done_ff     <= long_done_in;
      end
   end

   assign held = held_in;

endmodule
